// ===== hdl/frustum_cull_test_defines.svh =====
// Assertion macros used by the frustum culling checker.
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define FCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fct_pkg.sv =====
// Package: shared constants and types of the frustum culling block.
`timescale 1ns / 1ps
package fct_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int NUM_PLANES      = 6;
    localparam int PLANE_W         = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int N_W             = 14;
    localparam int W_W             = 22;
    localparam int FRAC_BITS       = 12;

    // Field positions inside a packed plane word
    localparam int NX_LSB = 0;
    localparam int NY_LSB = 14;
    localparam int NZ_LSB = 28;
    localparam int W_LSB  = 42;

    // Test kind codes
    localparam logic [1:0] FUNC_SPHERE = 2'd1;
    localparam int         FUNC_BOX_BIT = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT   = 3'd0,
        REG_RIGHT  = 3'd1,
        REG_TOP    = 3'd2,
        REG_BOTTOM = 3'd3,
        REG_NEAR   = 3'd4,
        REG_FAR    = 3'd5
    } cfg_reg_t;

    // Load enables for the per-plane pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

endpackage

// ===== hdl/fct_if.sv =====
// Interfaces: item, result and configuration channels.
`timescale 1ns / 1ps
interface fct_item_if #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] bz;
    logic [COORD_WIDTH-2:0]        radius;

    modport source (output valid, func, ax, ay, az, bx, by, bz, radius, input ready);
    modport sink   (input valid, func, ax, ay, az, bx, by, bz, radius, output ready);
endinterface

interface fct_result_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink   (input valid, visible, output ready);
endinterface

interface fct_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fct_pkg::CFG_IDX_W-1:0]  index;
    logic [fct_pkg::PLANE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/fct_plane_dist.sv =====
// Three-stage signed distance of one primitive against one plane.
`timescale 1ns / 1ps
module fct_plane_dist #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  fct_pkg::stage_en_t            en,
    input  logic [fct_pkg::PLANE_W-1:0]   plane,
    input  logic                          is_box,
    input  logic                          is_sphere,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] az,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    input  logic signed [COORD_WIDTH-1:0] bz,
    input  logic [COORD_WIDTH-2:0]        radius,
    output logic                          neg
);
    localparam int PW  = COORD_WIDTH + fct_pkg::N_W;
    localparam int WRW = ((COORD_WIDTH > fct_pkg::W_W) ? COORD_WIDTH : fct_pkg::W_W) + 1;
    localparam int AW  = WRW + 16;

    logic signed [fct_pkg::N_W-1:0] n_s [3];
    logic signed [COORD_WIDTH-1:0]  a_s [3];
    logic signed [COORD_WIDTH-1:0]  b_s [3];
    logic signed [COORD_WIDTH-1:0]  c_s [3];
    logic signed [fct_pkg::W_W-1:0] w_s;

    logic signed [PW-1:0]  prod_reg [3];
    logic signed [PW-1:0]  prod_next [3];
    logic signed [WRW-1:0] wr_reg, wr_next;
    logic signed [AW-1:0]  sum_a_reg, sum_a_next;
    logic signed [AW-1:0]  sum_b_reg, sum_b_next;
    logic signed [AW-1:0]  total;
    logic                  neg_reg, neg_next;

    assign n_s[0] = plane[fct_pkg::NX_LSB +: fct_pkg::N_W];
    assign n_s[1] = plane[fct_pkg::NY_LSB +: fct_pkg::N_W];
    assign n_s[2] = plane[fct_pkg::NZ_LSB +: fct_pkg::N_W];
    assign w_s    = plane[fct_pkg::W_LSB  +: fct_pkg::W_W];

    assign a_s[0] = ax;
    assign a_s[1] = ay;
    assign a_s[2] = az;
    assign b_s[0] = bx;
    assign b_s[1] = by;
    assign b_s[2] = bz;

    // Positive vertex: max corner where the normal component is positive
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (is_box && !n_s[k][fct_pkg::N_W-1] && (|n_s[k]))
                c_s[k] = b_s[k];
            else
                c_s[k] = a_s[k];
            prod_next[k] = PW'(n_s[k]) * PW'(c_s[k]);
        end
        if (is_sphere)
            wr_next = WRW'(w_s) + WRW'($signed({1'b0, radius}));
        else
            wr_next = WRW'(w_s);
    end

    always_comb
    begin
        sum_a_next = AW'(prod_reg[0]) + AW'(prod_reg[1]);
        sum_b_next = AW'(prod_reg[2]) + (AW'(wr_reg) <<< fct_pkg::FRAC_BITS);
        total      = sum_a_reg + sum_b_reg;
        neg_next   = total[AW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod_reg <= prod_next;
            wr_reg   <= wr_next;
        end
        if (en.s2)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
        if (en.s3)
            neg_reg <= neg_next;
    end

    assign neg = neg_reg;

endmodule

// ===== hdl/frustum_cull_test.sv =====
// Top level: frustum culling of points, spheres and boxes against six planes.
// Pipeline: four register stages from the input transfer to the result.
// Throughput: one item per cycle unless the result side stalls, set by the six plane
//   pipelines running in parallel.
// Reset: rst_n clears all valid bits and all six planes (every primitive visible).
`timescale 1ns / 1ps
module frustum_cull_test #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    fct_cfg_if.sink      cfg,
    fct_item_if.sink     item,
    fct_result_if.source result
);
    // Plane registers, to be written only while the pipeline is idle; the block does not check it
    logic [fct_pkg::PLANE_W-1:0] plane_reg  [fct_pkg::NUM_PLANES];
    logic [fct_pkg::PLANE_W-1:0] plane_next [fct_pkg::NUM_PLANES];

    // Valid bits of the four stages: products, partial sums, sign flags, result
    logic valid1_reg, valid2_reg, valid3_reg, valid4_reg;
    logic adv1, adv2, adv3, adv4;
    logic visible_reg;

    fct_pkg::stage_en_t         en;
    logic [fct_pkg::NUM_PLANES-1:0] neg;

    logic is_box;
    logic is_sphere;

    // Configuration: always ready; drop writes to indexes past the plane list
    assign cfg.ready = 1'b1;

    always_comb
    begin
        plane_next = plane_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                fct_pkg::REG_LEFT:   plane_next[fct_pkg::REG_LEFT]   = cfg.data;
                fct_pkg::REG_RIGHT:  plane_next[fct_pkg::REG_RIGHT]  = cfg.data;
                fct_pkg::REG_TOP:    plane_next[fct_pkg::REG_TOP]    = cfg.data;
                fct_pkg::REG_BOTTOM: plane_next[fct_pkg::REG_BOTTOM] = cfg.data;
                fct_pkg::REG_NEAR:   plane_next[fct_pkg::REG_NEAR]   = cfg.data;
                fct_pkg::REG_FAR:    plane_next[fct_pkg::REG_FAR]    = cfg.data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fct_pkg::NUM_PLANES; i++)
                plane_reg[i] <= '0;
        end
        else
        begin
            plane_reg <= plane_next;
        end
    end

    // Stall chain: a stage takes new content when it is empty or its
    // successor advances, so bubbles squeeze out while the result waits.
    assign adv4 = !valid4_reg || result.ready;
    assign adv3 = !valid3_reg || adv4;
    assign adv2 = !valid2_reg || adv3;
    assign adv1 = !valid1_reg || adv2;

    assign item.ready = adv1;

    assign en.s1 = adv1;
    assign en.s2 = adv2;
    assign en.s3 = adv3;

    // Kind decode: bit 1 set means box, so code 3 also runs as a box
    assign is_box    = item.func[fct_pkg::FUNC_BOX_BIT];
    assign is_sphere = (item.func == fct_pkg::FUNC_SPHERE);

    // One distance pipeline per plane
    for (genvar p = 0; p < fct_pkg::NUM_PLANES; p++)
    begin : g_plane
        fct_plane_dist #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_dist (
            .clk       (clk),
            .en        (en),
            .plane     (plane_reg[p]),
            .is_box    (is_box),
            .is_sphere (is_sphere),
            .ax        (item.ax),
            .ay        (item.ay),
            .az        (item.az),
            .bx        (item.bx),
            .by        (item.by),
            .bz        (item.bz),
            .radius    (item.radius),
            .neg       (neg[p])
        );
    end

    // Advance valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                valid1_reg <= item.valid;
            if (adv2)
                valid2_reg <= valid1_reg;
            if (adv3)
                valid3_reg <= valid2_reg;
            if (adv4)
                valid4_reg <= valid3_reg;
        end
    end

    // Output register: visible unless some plane reports a negative distance
    always_ff @(posedge clk)
    begin
        if (adv4)
            visible_reg <= ~(|neg);
    end

    assign result.valid   = valid4_reg;
    assign result.visible = visible_reg;

endmodule

// ===== hdl/fct_checker.sv =====
// Checker: port-level assertions for the frustum culling block, with its bind.
`timescale 1ns / 1ps
`include "frustum_cull_test_defines.svh"
module fct_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_ready,
    input logic result_valid,
    input logic result_ready,
    input logic result_visible
);
    logic       item_xfer;
    logic       result_xfer;
    logic [2:0] count_reg, count_next;

    assign item_xfer   = item_valid && item_ready;
    assign result_xfer = result_valid && result_ready;

    // Items in flight: accepted but not yet delivered
    always_comb
    begin
        count_next = count_reg + {2'b00, item_xfer} - {2'b00, result_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 3'd0;
        else
            count_reg <= count_next;
    end

    `FCT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_visible), "result dropped or changed while stalled")
    `FCT_ASSERT_NOW(a_no_phantom, result_valid, count_reg != 3'd0, "result with no item in flight")
    `FCT_ASSERT_NOW(a_full_bound, (count_reg == 3'd4) && item_ready, result_ready, "pipeline full yet ready without a result transfer")
    `FCT_ASSERT_NEXT(a_latency, item_xfer ##1 result_ready ##1 result_ready ##1 result_ready, result_valid, "result late through a free pipeline")

endmodule

bind frustum_cull_test fct_checker u_fct_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_visible (result.visible)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the frustum culling block: stimulus, visibility predictor, checks.
`timescale 1ns / 1ps
module tb_top;
    import fct_pkg::*;

    localparam int CW    = COORD_WIDTH_DEF;
    localparam int ONE   = 1 << FRAC_BITS;            // 1.0 in Q11.12 and in Q1.12
    localparam int C_MAX = (1 << (CW - 1)) - 1;
    localparam int C_MIN = -(1 << (CW - 1));
    localparam int R_MAX = (1 << (CW - 1)) - 1;
    localparam int N_MAX = (1 << (N_W - 1)) - 1;
    localparam int N_MIN = -(1 << (N_W - 1));
    localparam int W_MAX = (1 << (W_W - 1)) - 1;
    localparam int W_MIN = -(1 << (W_W - 1));

    localparam int ITEMS_PER_PHASE = 150;
    localparam int N_PHASES        = 8;
    localparam int SETTLE_CYCLES   = 8;     // four register stages, with margin
    localparam int QUIET_LIMIT     = 2000;  // cycles with no transfer on any channel

    // Test kinds not named in the package; code 3 decodes as a box
    localparam logic [1:0] FUNC_POINT   = 2'd0;
    localparam logic [1:0] FUNC_BOX     = 2'd2;
    localparam logic [1:0] FUNC_BOX_ALT = 2'd3;

    // Register indexes beyond the six planes; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [1:0]           func;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] bz;
        logic [CW-2:0]        radius;
    } cull_item_t;

    typedef enum {PL_ZERO, PL_BOX, PL_TILTED, PL_RANDOM, PL_EXTREME} plane_set_t;

    // Plane copy, visibility predictor and the queue of pending visibility flags.
    class visibility_board;
        logic [PLANE_W-1:0] planes [NUM_PLANES];
        bit                 visible_q [$];
        int                 mismatches;
        int                 results_seen;

        function new();
            foreach (planes[p])
                planes[p] = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_plane(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] data);
            if (idx < NUM_PLANES)
                planes[idx] = data;
        endfunction

        // Culled when the tested vertex or sphere lies behind any plane.
        function bit predict_visible(cull_item_t it);
            longint a [3];
            longint b [3];
            longint n [3];
            longint r;
            longint acc;
            longint c;
            bit     vis;
            vis  = 1'b1;
            a[0] = $signed(it.ax);
            a[1] = $signed(it.ay);
            a[2] = $signed(it.az);
            b[0] = $signed(it.bx);
            b[1] = $signed(it.by);
            b[2] = $signed(it.bz);
            r    = it.radius;
            for (int p = 0; p < NUM_PLANES; p++) begin
                n[0] = $signed(planes[p][NX_LSB +: N_W]);
                n[1] = $signed(planes[p][NY_LSB +: N_W]);
                n[2] = $signed(planes[p][NZ_LSB +: N_W]);
                acc  = $signed(planes[p][W_LSB +: W_W]);
                acc  = acc * ONE;
                for (int k = 0; k < 3; k++) begin
                    c   = (it.func[FUNC_BOX_BIT] && n[k] > 0) ? b[k] : a[k];
                    acc = acc + n[k] * c;
                end
                if (it.func == FUNC_SPHERE)
                    acc = acc + r * ONE;
                if (acc < 0)
                    vis = 1'b0;
            end
            return vis;
        endfunction

        function void note_item(cull_item_t it);
            visible_q.push_back(predict_visible(it));
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("tb_top: %s", msg);
        endfunction

        function void check_visible(logic got);
            bit want;
            results_seen++;
            if (visible_q.size() == 0) begin
                flag($sformatf("result %0d arrived with nothing pending (visible=%b)",
                               results_seen, got));
                return;
            end
            want = visible_q.pop_front();
            if (got !== want)
                flag($sformatf("result %0d visible mismatch: expected %0b, got %b",
                               results_seen, want, got));
        endfunction

        function int pending();
            return visible_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   no_stalls = 1'b0;
    int   quiet_cycles = 0;

    visibility_board board = new();

    fct_item_if #(.COORD_WIDTH(CW)) item_bus ();
    fct_result_if                   result_bus ();
    fct_cfg_if                      cfg_bus ();

    frustum_cull_test #(.COORD_WIDTH(CW)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .item   (item_bus),
        .result (result_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_stalls)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int w);
        return {w[W_W-1:0], nz[N_W-1:0], ny[N_W-1:0], nx[N_W-1:0]};
    endfunction

    function automatic int ext_norm();
        case ($urandom_range(0, 2))
            0:       return N_MIN;
            1:       return N_MAX;
            default: return 0;
        endcase
    endfunction

    // Coordinate mix: mostly near the origin so planes split the items, some full
    // range to toggle every bit, some pinned at the extremes.
    function automatic int rand_coord();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12)
            return int'($urandom_range(0, 1 << 22)) - (1 << 21);
        if (sel < 17)
            return $urandom();
        case ($urandom_range(0, 3))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic cull_item_t mk(logic [1:0] f, int ax, int ay, int az,
                                      int bx, int by, int bz, int rad);
        cull_item_t it;
        it.func   = f;
        it.ax     = ax[CW-1:0];
        it.ay     = ay[CW-1:0];
        it.az     = az[CW-1:0];
        it.bx     = bx[CW-1:0];
        it.by     = by[CW-1:0];
        it.bz     = bz[CW-1:0];
        it.radius = rad[CW-2:0];
        return it;
    endfunction

    // Drop item valid and hold until every pending visibility flag has come back.
    task automatic hold_until_drained();
        item_bus.valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    // Valid is left high so back-to-back items need no toggle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [PLANE_W-1:0] data);
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        cfg_bus.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        board.write_plane(idx, data);
        @(negedge clk);
    endtask

    task automatic push_item(input cull_item_t it, input int gap);
        if (gap > 0)
        begin
            item_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_bus.func   = it.func;
        item_bus.ax     = it.ax;
        item_bus.ay     = it.ay;
        item_bus.az     = it.az;
        item_bus.bx     = it.bx;
        item_bus.by     = it.by;
        item_bus.bz     = it.bz;
        item_bus.radius = it.radius;
        item_bus.valid  = 1'b1;
        do
            @(posedge clk);
        while (!item_bus.ready);
        board.note_item(it);
        @(negedge clk);
    endtask

    // Reprogram all six planes while the pipeline is empty. half > 0 fixes the
    // half-size of the box frustum; otherwise each setting draws its own values.
    task automatic load_planes(input plane_set_t kind, input int half);
        logic [PLANE_W-1:0] words [NUM_PLANES];
        int                 hx;
        int                 hy;
        int                 hz;
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        hx = (half > 0) ? half : $urandom_range(1 << 14, W_MAX);
        hy = (half > 0) ? half : $urandom_range(1 << 14, W_MAX);
        hz = (half > 0) ? half : $urandom_range(1 << 14, W_MAX);
        foreach (words[p])
        begin
            case (kind)
                PL_ZERO:    words[p] = '0;
                PL_TILTED:  words[p] = pack_plane(int'($urandom_range(0, 2 * ONE)) - ONE,
                                                  int'($urandom_range(0, 2 * ONE)) - ONE,
                                                  int'($urandom_range(0, 2 * ONE)) - ONE,
                                                  int'($urandom_range(0, W_MAX + (1 << 18)))
                                                      - (1 << 18));
                PL_RANDOM:  words[p] = {$urandom(), $urandom()};
                PL_EXTREME: words[p] = pack_plane(ext_norm(), ext_norm(), ext_norm(),
                                                  $urandom_range(0, 1) ? W_MAX : W_MIN);
                default:    words[p] = '0;
            endcase
        end
        if (kind == PL_BOX)
        begin
            // Axis-aligned frustum: |x| <= hx, |y| <= hy, |z| <= hz
            words[REG_LEFT]   = pack_plane(ONE, 0, 0, hx);
            words[REG_RIGHT]  = pack_plane(-ONE, 0, 0, hx);
            words[REG_TOP]    = pack_plane(0, -ONE, 0, hy);
            words[REG_BOTTOM] = pack_plane(0, ONE, 0, hy);
            words[REG_NEAR]   = pack_plane(0, 0, ONE, hz);
            words[REG_FAR]    = pack_plane(0, 0, -ONE, hz);
        end
        foreach (words[p])
            write_reg(cfg_reg_t'(p), words[p]);
        // Out-of-range indexes: the block must leave the planes alone
        write_reg(REG_SPARE_LO, {$urandom(), $urandom()});
        write_reg(REG_SPARE_HI, '1);
        cfg_bus.valid = 1'b0;
    endtask

    // Result side back-pressure: random stalls between ready stretches.
    initial
    begin
        int stall;
        result_bus.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                result_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_bus.ready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    // Check every result transfer against the oldest pending flag.
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
            board.check_visible(result_bus.visible);
    end

    // Watchdog: restart on any transfer, give up after a long silence.
    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready) ||
            (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top: watchdog expired, %0d flags still pending", board.pending());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        plane_set_t sched [N_PHASES];
        int         ax;
        int         ay;
        int         az;
        int         bx;
        int         by;
        int         bz;
        int         rad;
        int         sel;
        logic [1:0] f;
        int         h;

        sched = '{PL_BOX, PL_TILTED, PL_RANDOM, PL_EXTREME,
                  PL_BOX, PL_TILTED, PL_ZERO, PL_BOX};
        h     = 16 * ONE;

        // Drive every input to a known value before reset lets go
        rst_n           = 1'b0;
        item_bus.valid  = 1'b0;
        item_bus.func   = FUNC_POINT;
        item_bus.ax     = '0;
        item_bus.ay     = '0;
        item_bus.az     = '0;
        item_bus.bx     = '0;
        item_bus.by     = '0;
        item_bus.bz     = '0;
        item_bus.radius = '0;
        cfg_bus.valid   = 1'b0;
        cfg_bus.index   = REG_LEFT;
        cfg_bus.data    = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Planes still at reset: everything must come back visible
        push_item(mk(FUNC_POINT, C_MAX, C_MIN, C_MAX, 0, 0, 0, 0), pick_gap());
        push_item(mk(FUNC_SPHERE, C_MIN, C_MIN, C_MIN, 0, 0, 0, R_MAX), pick_gap());
        push_item(mk(FUNC_BOX_ALT, C_MIN, C_MAX, 0, C_MAX, C_MIN, -1, 0), pick_gap());

        // Cube frustum of half-size 16.0 for the hand-picked cases
        load_planes(PL_BOX, h);
        push_item(mk(FUNC_POINT, 0, 0, 0, 0, 0, 0, 0), pick_gap());
        // point exactly on the right plane: distance zero stays visible
        push_item(mk(FUNC_POINT, h, 0, 0, 0, 0, 0, 0), pick_gap());
        push_item(mk(FUNC_POINT, h + 1, 0, 0, 0, 0, 0, 0), pick_gap());
        // unused box corner and radius at their extremes must not matter
        push_item(mk(FUNC_POINT, 0, -h - 1, 0, C_MAX, C_MIN, C_MAX, R_MAX), pick_gap());
        push_item(mk(FUNC_POINT, 0, 0, h, C_MIN, C_MAX, C_MIN, R_MAX), pick_gap());
        push_item(mk(FUNC_POINT, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0), pick_gap());
        // sphere just touching the right plane, then one step short of it
        push_item(mk(FUNC_SPHERE, 20 * ONE, 0, 0, C_MIN, C_MIN, C_MIN, 4 * ONE), pick_gap());
        push_item(mk(FUNC_SPHERE, 20 * ONE, 0, 0, 0, 0, 0, 4 * ONE - 1), pick_gap());
        push_item(mk(FUNC_SPHERE, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, R_MAX),
                  pick_gap());
        push_item(mk(FUNC_SPHERE, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0), pick_gap());
        push_item(mk(FUNC_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, R_MAX), pick_gap());
        push_item(mk(FUNC_BOX, 17 * ONE, 0, 0, 18 * ONE, ONE, ONE, 0), pick_gap());
        // box whose min face lies on the right plane
        push_item(mk(FUNC_BOX, h, 0, 0, h + ONE, ONE, ONE, 0), pick_gap());
        // inverted corners: the positive-vertex rule runs without reordering
        push_item(mk(FUNC_BOX, 18 * ONE, 18 * ONE, 18 * ONE,
                     -18 * ONE, -18 * ONE, -18 * ONE, 0), pick_gap());
        // kind code 3 behaves as a box
        push_item(mk(FUNC_BOX_ALT, 17 * ONE, 0, 0, 18 * ONE, ONE, ONE, 0), pick_gap());
        push_item(mk(FUNC_BOX_ALT, -ONE, -ONE, -ONE, ONE, ONE, ONE, R_MAX), pick_gap());

        // Random phases, each under its own plane setting
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            load_planes(sched[ph], 0);
            no_stalls = (ph == 4);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // hold the sender once per phase until the pipeline empties
                if (k == ITEMS_PER_PHASE / 2)
                    hold_until_drained();
                sel = $urandom_range(0, 15);
                if (sel < 5)
                    f = FUNC_POINT;
                else if (sel < 10)
                    f = FUNC_SPHERE;
                else if (sel < 15)
                    f = FUNC_BOX;
                else
                    f = FUNC_BOX_ALT;
                ax = rand_coord();
                ay = rand_coord();
                az = rand_coord();
                if ($urandom_range(0, 6) == 0)
                begin
                    bx = rand_coord();
                    by = rand_coord();
                    bz = rand_coord();
                end
                else
                begin
                    bx = ax + int'($urandom_range(0, 1 << 20));
                    by = ay + int'($urandom_range(0, 1 << 20));
                    bz = az + int'($urandom_range(0, 1 << 20));
                end
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    rad = $urandom_range(0, 1 << 20);
                else if (sel < 9)
                    rad = $urandom();
                else
                    rad = $urandom_range(0, 1) ? R_MAX : 0;
                push_item(mk(f, ax, ay, az, bx, by, bz, rad), pick_gap());
            end
        end
        no_stalls = 1'b0;

        // Drain, then give stray results a chance to show up
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.pending() != 0)
            board.flag($sformatf("%0d visibility flags never arrived", board.pending()));
        if (board.mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/fct_pkg.sv
hdl/fct_if.sv
hdl/fct_plane_dist.sv
hdl/frustum_cull_test.sv
hdl/fct_checker.sv
dv/tb_top.sv
